>>> src/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache tag store package
// Field widths, command and status codes, and the structures that pass
// between the controller and the row of entry cells.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int CMD_W   = 2;
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int SEL_W   = 5;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 8;
  localparam int STAT_W  = 2;
  // Wide enough for any entry index up to the largest supported cache.
  localparam int IDX_W   = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_GET     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PIN     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNPIN   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_HIT,
    OP_TAKE,
    OP_RELEASE,
    OP_PIN,
    OP_UNPIN
  } op_t;

  // Running result of a lookup as it moves from cell to cell.
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic               filled;
    logic [IDX_W-1:0]   hit_idx;
    logic               vfound;
    logic [IDX_W-1:0]   vidx;
    logic [STAMP_W-1:0] vstamp;
  } acc_t;

  // Update broadcast to every cell; only the addressed cell acts on it.
  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block;
    logic [STAMP_W-1:0] now;
  } upd_t;

endpackage

>>> src/bbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bbc_req_if import bbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [DEV_W-1:0]   device;
  logic [BLK_W-1:0]   block_number;
  logic [SEL_W-1:0]   entry_select;
  logic [STAMP_W-1:0] now;

  modport source (output valid, command, device, block_number, entry_select, now,
                  input ready);
  modport sink (input valid, command, device, block_number, entry_select, now,
                output ready);
endinterface

interface bbc_rsp_if import bbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SEL_W-1:0]  entry_index;
  logic              hit;
  logic              fill_needed;
  logic [STAT_W-1:0] status;

  modport source (output valid, entry_index, hit, fill_needed, status,
                  input ready);
  modport sink (input valid, entry_index, hit, fill_needed, status,
                output ready);
endinterface

>>> src/block_buffer_cache_lru_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache tag store with least-recently-released replacement
// A row of entry cells walked by a lookup token, and a small controller
// that launches lookups, commits updates and holds the response.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                                           | Transfer
//  --------+-----+---------------------------------------------------+----------------
//  req     | in  | command, device, block_number, entry_select, now  | valid && ready
//  rsp     | out | entry_index, hit, fill_needed, status             | valid && ready
//
// A get is registered at its transfer; the lookup token then steps through
// one cell per clock, the walk result is turned into a registered update,
// and the commit stage applies it and loads the response. Release, pin and
// unpin skip the walk and go straight to the commit.
// One command is processed at a time; req.ready is high only while idle.
// A response that is not taken stalls the commit, and with it further requests.
// Reset is synchronous and clears every entry.
//
module block_buffer_cache_lru_top import bbc_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic clk,
  input  logic rst,
  bbc_req_if.sink   req,
  bbc_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_COMMIT
  } state_t;

  state_t state;

  // Pending update and the response that goes with it.
  upd_t              upd;
  logic [SEL_W-1:0]  res_idx;
  logic              res_hit;
  logic              res_fill;
  logic [STAT_W-1:0] res_status;

  acc_t               chain [ENTRIES+1];
  logic [ENTRIES-1:0] zero_vec;
  upd_t               cell_upd;

  logic req_fire;
  logic start;
  logic launch;
  logic out_free;
  logic commit_fire;
  logic dec_err;
  acc_t walk_end;

  assign req.ready   = (state == S_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign start       = req_fire && (req.command == CMD_GET);
  assign out_free    = !rsp.valid || rsp.ready;
  assign commit_fire = (state == S_COMMIT) && out_free;
  assign walk_end    = chain[ENTRIES];

  // The token enters the row the cycle after the transfer, once the
  // requested device and block sit in the update register.
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= start;
    end
  end

  // The lookup token enters the first cell empty.
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch;
  end

  // Cells only act on an update in the cycle the response is loaded, so a
  // stalled response never applies the same update twice.
  always_comb begin
    cell_upd = upd;
    if (!commit_fire) begin
      cell_upd.op = OP_NONE;
    end
  end

  // A decrement on an entry whose count is already zero reports an error.
  // An index beyond the last entry addresses no cell and so reports none.
  assign dec_err = ((upd.op == OP_RELEASE) || (upd.op == OP_UNPIN)) && (|zero_vec);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    bbc_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .acc_in   (chain[i]),
      .acc_out  (chain[i+1]),
      .upd      (cell_upd),
      .sel_zero (zero_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      upd.op    <= OP_NONE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !commit_fire) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            upd.idx    <= IDX_W'(req.entry_select);
            upd.device <= req.device;
            upd.block  <= req.block_number;
            upd.now    <= req.now;
            res_idx    <= req.entry_select;
            res_hit    <= 1'b0;
            res_fill   <= 1'b0;
            res_status <= ST_OK;
            unique case (req.command)
              CMD_RELEASE: begin
                upd.op <= OP_RELEASE;
                state  <= S_COMMIT;
              end
              CMD_PIN: begin
                upd.op <= OP_PIN;
                state  <= S_COMMIT;
              end
              CMD_UNPIN: begin
                upd.op <= OP_UNPIN;
                state  <= S_COMMIT;
              end
              default: begin
                upd.op <= OP_NONE;
                state  <= S_WALK;
              end
            endcase
          end
        end
        S_WALK: begin
          if (walk_end.valid) begin
            state <= S_COMMIT;
            if (walk_end.hit) begin
              upd.op   <= OP_HIT;
              upd.idx  <= walk_end.hit_idx;
              res_idx  <= walk_end.hit_idx[SEL_W-1:0];
              res_hit  <= 1'b1;
              res_fill <= !walk_end.filled;
            end else if (walk_end.vfound) begin
              upd.op   <= OP_TAKE;
              upd.idx  <= walk_end.vidx;
              res_idx  <= walk_end.vidx[SEL_W-1:0];
              res_fill <= 1'b1;
            end else begin
              // Every entry is referenced: nothing changes.
              upd.op     <= OP_NONE;
              res_idx    <= '0;
              res_status <= ST_FULL;
            end
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            rsp.valid       <= 1'b1;
            rsp.entry_index <= res_idx;
            rsp.hit         <= res_hit;
            rsp.fill_needed <= res_fill;
            rsp.status      <= dec_err ? ST_ZERO : res_status;
            upd.op          <= OP_NONE;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/bbc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache entry cell
// Holds one entry, folds it into the passing lookup result and applies
// updates addressed to it.
// ----------------------------------------------------------------------------
module bbc_cell import bbc_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  acc_t             acc_in,
  output acc_t             acc_out,
  input  upd_t             upd,
  output logic             sel_zero
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic               present;
  logic [DEV_W-1:0]   device;
  logic [BLK_W-1:0]   block;
  logic               filled;
  logic [CNT_W-1:0]   count;
  logic [STAMP_W-1:0] stamp;

  logic             match;
  logic             free;
  logic             sel;
  logic [CNT_W-1:0] count_inc;
  acc_t             acc_next;

  assign match     = present && (device == upd.device) && (block == upd.block);
  assign free      = (count == '0);
  assign sel       = (upd.idx == MY_IDX);
  assign sel_zero  = sel && free;
  assign count_inc = (count == COUNT_MAX) ? count : count + CNT_W'(1);

  always_comb begin
    acc_next = acc_in;
    if (!acc_in.hit && match) begin
      acc_next.hit     = 1'b1;
      acc_next.hit_idx = MY_IDX;
      acc_next.filled  = filled;
    end
    // Strict less-than keeps the lowest index on equal stamps.
    if (free && (!acc_in.vfound || (stamp < acc_in.vstamp))) begin
      acc_next.vfound = 1'b1;
      acc_next.vidx   = MY_IDX;
      acc_next.vstamp = stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_out.valid <= 1'b0;
    end else begin
      acc_out <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      device  <= '0;
      block   <= '0;
      filled  <= 1'b0;
      count   <= '0;
      stamp   <= '0;
    end else if (sel) begin
      unique case (upd.op)
        OP_HIT: begin
          count  <= count_inc;
          filled <= 1'b1;
        end
        OP_TAKE: begin
          present <= 1'b1;
          device  <= upd.device;
          block   <= upd.block;
          count   <= CNT_W'(1);
          stamp   <= upd.now;
          filled  <= 1'b1;
        end
        OP_PIN: begin
          count <= count_inc;
        end
        OP_RELEASE: begin
          if (!free) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              stamp <= upd.now;
            end
          end
        end
        OP_UNPIN: begin
          if (!free) begin
            count <= count - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
